[hdl/itop_pkg.sv]
`timescale 1ns / 1ps

package itop_pkg;

  // Characters with a role in the conversion
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_NONE   = 8'h00;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // Operator ranks
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;
  localparam logic [1:0] RANK_POW  = 2'd3;

  function automatic logic [1:0] rank_of(input logic [7:0] c);
    logic [1:0] r;
    unique case (c)
      CH_PLUS, CH_MINUS:          r = RANK_ADD;
      CH_STAR, CH_SLASH, CH_PCT:  r = RANK_MUL;
      CH_CARET:                   r = RANK_POW;
      default:                    r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Controller -> datapath commands
  typedef struct packed {
    logic txt_store;  // store incoming char (or flag overflow)
    logic scan_load;  // scan index <= text count
    logic scan_rd;    // index--, read text at new index
    logic latch_cur;  // hold current operator
    logic stack_rd;   // read top of stack
    logic push;       // push onto stack
    logic push_cur;   // push source: 1 current operator, 0 text char
    logic pop;        // drop top of stack
    logic emit;       // append to reversed prefix buffer
    logic emit_top;   // emit source: 1 stack top, 0 text char
    logic rem_load;   // output countdown <= prefix length
    logic out_rd;     // countdown--, read prefix buffer
    logic out_load;   // load output register
    logic out_empty;  // output item is the empty-result marker
    logic clear;      // return text and prefix counts and overflow flag to reset values
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic scan_done;
    logic depth_zero;
    logic pf_zero;
    logic rem_zero;
    logic out_free;
    logic txt_operand;
    logic txt_lparen;
    logic txt_rparen;
    logic txt_op;
    logic top_rparen;
    logic top_pops;
  } sts_t;

endpackage

[hdl/infix_to_prefix_converter.sv]
`timescale 1ns / 1ps

// Infix to prefix converter.
// s_axis carries one ASCII character of an infix expression per transaction;
// tlast marks the final character. Letters and digits are operands, + - * / %
// ^ are operators (^ binds tightest and is right associative), parentheses
// group, anything else is ignored. Up to MAX_LEN characters are kept; more
// are dropped and every result of that expression then has status 1.
// m_axis returns the prefix form, one character per transaction, with tlast on
// the final one and the status in tuser. An expression with no prefix
// characters yields a single transaction with data 0 and status 2 (or 1).
// Throughput: characters load at one per cycle while s_axis_tready is high.
// After the final character the reverse scan reads each stored character
// back, pushes and pops the operator stack, and then flushes the stack.
// Results leave through the registered reads of the single-port text, stack
// and prefix buffers; the next result is not read until the previous one is
// in the output register. s_axis_tready drops for the whole conversion and
// returns as the last result enters the output register.
// A stalled receiver holds the output register and the result sequence.
// Reset clears all counters and the output valid; no clearing pass is needed.

module infix_to_prefix_converter #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o,   // out_last
  output logic [1:0] m_axis_tuser_o    // [1:0] status
);
  import itop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  itop_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itop_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_char_i    (s_axis_tdata_i),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_char_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

[hdl/itop_datapath.sv]
`timescale 1ns / 1ps

module itop_datapath #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itop_pkg::cmd_t cmd_i,
  input  logic [7:0]    in_char_i,
  output itop_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_char_o,
  output logic          out_last_o,
  output logic [1:0]    out_status_o
);
  import itop_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  logic [7:0] text_mem [MAX_LEN];
  logic [7:0] stack_mem[MAX_LEN];
  logic [7:0] pf_mem   [MAX_LEN];

  logic [CNT_W-1:0] text_cnt_q, idx_q, depth_q, pf_cnt_q, rem_q;
  logic             too_long_q, out_valid_q;
  logic [7:0]       text_rd_q, stack_rd_q, pf_rd_q, cur_q, out_char_q;
  logic             out_last_q;
  logic [1:0]       out_status_q;

  logic [CNT_W-1:0] idx_dec, depth_dec, rem_dec;
  logic [7:0]       push_data, emit_data;
  logic [1:0]       top_rank, cur_rank, status_now;
  logic             out_free;

  assign idx_dec   = idx_q - ONE;
  assign depth_dec = depth_q - ONE;
  assign rem_dec   = rem_q - ONE;
  assign push_data = cmd_i.push_cur ? cur_q : text_rd_q;
  assign emit_data = cmd_i.emit_top ? stack_rd_q : text_rd_q;
  assign top_rank  = rank_of(stack_rd_q);
  assign cur_rank  = rank_of(cur_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    if (too_long_q) begin
      status_now = ST_TOO_LONG;
    end else if (pf_cnt_q == '0) begin
      status_now = ST_EMPTY;
    end else begin
      status_now = ST_OK;
    end
  end

  // Memories and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.txt_store && (text_cnt_q < FULL)) begin
      text_mem[text_cnt_q[ADDR_W-1:0]] <= in_char_i;
    end
    if (cmd_i.scan_rd) begin
      text_rd_q <= text_mem[idx_dec[ADDR_W-1:0]];
    end
    if (cmd_i.push) begin
      stack_mem[depth_q[ADDR_W-1:0]] <= push_data;
    end
    if (cmd_i.stack_rd) begin
      stack_rd_q <= stack_mem[depth_dec[ADDR_W-1:0]];
    end
    if (cmd_i.emit) begin
      pf_mem[pf_cnt_q[ADDR_W-1:0]] <= emit_data;
    end
    if (cmd_i.out_rd) begin
      pf_rd_q <= pf_mem[rem_dec[ADDR_W-1:0]];
    end
    if (cmd_i.latch_cur) begin
      cur_q <= text_rd_q;
    end
    if (cmd_i.out_load) begin
      out_char_q   <= cmd_i.out_empty ? CH_NONE : pf_rd_q;
      out_last_q   <= cmd_i.out_empty || (rem_q == '0);
      out_status_q <= status_now;
    end
  end

  // Counters and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_cnt_q  <= '0;
      idx_q       <= '0;
      depth_q     <= '0;
      pf_cnt_q    <= '0;
      rem_q       <= '0;
      too_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.txt_store) begin
        if (text_cnt_q < FULL) begin
          text_cnt_q <= text_cnt_q + ONE;
        end else begin
          too_long_q <= 1'b1;
        end
      end
      if (cmd_i.scan_load) begin
        idx_q <= text_cnt_q;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_dec;
      end
      if (cmd_i.push) begin
        depth_q <= depth_q + ONE;
      end else if (cmd_i.pop) begin
        depth_q <= depth_dec;
      end
      if (cmd_i.emit) begin
        pf_cnt_q <= pf_cnt_q + ONE;
      end
      if (cmd_i.rem_load) begin
        rem_q <= pf_cnt_q;
      end else if (cmd_i.out_rd) begin
        rem_q <= rem_dec;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        text_cnt_q <= '0;
        pf_cnt_q   <= '0;
        too_long_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_done   = (idx_q == '0);
  assign sts_o.depth_zero  = (depth_q == '0);
  assign sts_o.pf_zero     = (pf_cnt_q == '0);
  assign sts_o.rem_zero    = (rem_q == '0);
  assign sts_o.out_free    = out_free;
  assign sts_o.txt_operand = is_operand(text_rd_q);
  assign sts_o.txt_lparen  = (text_rd_q == CH_LPAREN);
  assign sts_o.txt_rparen  = (text_rd_q == CH_RPAREN);
  assign sts_o.txt_op      = (rank_of(text_rd_q) != RANK_NONE);
  assign sts_o.top_rparen  = (stack_rd_q == CH_RPAREN);
  assign sts_o.top_pops    = (top_rank > cur_rank) ||
                             ((top_rank == cur_rank) && (cur_q == CH_CARET));

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

  a_text_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_cnt_q <= FULL) else $error("text count beyond buffer");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= FULL) else $error("stack depth beyond buffer");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free) else $error("output register overwritten");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (depth_q != '0)) else $error("pop on empty stack");

endmodule

[hdl/itop_controller.sv]
`timescale 1ns / 1ps

module itop_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  itop_pkg::sts_t sts_i,
  output itop_pkg::cmd_t cmd_o
);
  import itop_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCAN, S_CHAR, S_PAREN_RD, S_PAREN, S_OP_RD, S_OP,
    S_FLUSH_RD, S_FLUSH, S_OUT_START, S_OUT_RD, S_OUT_LD
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   accept;

  assign accept = in_valid_i && ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.txt_store = accept;
        if (accept && in_last_i) state_d = S_START;
      end
      S_START: begin
        cmd_o.scan_load = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_FLUSH_RD;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        priority if (sts_i.txt_operand) begin
          cmd_o.emit = 1'b1;
          state_d = S_SCAN;
        end else if (sts_i.txt_rparen) begin
          cmd_o.push = 1'b1;
          state_d = S_SCAN;
        end else if (sts_i.txt_lparen) begin
          state_d = S_PAREN_RD;
        end else if (sts_i.txt_op) begin
          cmd_o.latch_cur = 1'b1;
          state_d = S_OP_RD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_PAREN_RD: begin
        if (sts_i.depth_zero) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.stack_rd = 1'b1;
          state_d = S_PAREN;
        end
      end
      S_PAREN: begin
        cmd_o.pop = 1'b1;
        if (sts_i.top_rparen) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_top = 1'b1;
          state_d = S_PAREN_RD;
        end
      end
      S_OP_RD: begin
        if (sts_i.depth_zero) begin
          cmd_o.push     = 1'b1;
          cmd_o.push_cur = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.stack_rd = 1'b1;
          state_d = S_OP;
        end
      end
      S_OP: begin
        if (sts_i.top_pops) begin
          cmd_o.pop      = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_top = 1'b1;
          state_d = S_OP_RD;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.push_cur = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_FLUSH_RD: begin
        if (sts_i.depth_zero) begin
          state_d = S_OUT_START;
        end else begin
          cmd_o.stack_rd = 1'b1;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.pop      = 1'b1;
        cmd_o.emit     = !sts_i.top_rparen;
        cmd_o.emit_top = 1'b1;
        state_d = S_FLUSH_RD;
      end
      S_OUT_START: begin
        cmd_o.rem_load = 1'b1;
        state_d = S_OUT_RD;
      end
      S_OUT_RD: begin
        if (sts_i.pf_zero) begin
          if (sts_i.out_free) begin
            cmd_o.out_load  = 1'b1;
            cmd_o.out_empty = 1'b1;
            cmd_o.clear     = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.out_rd = 1'b1;
          state_d = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.rem_zero) begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (state_q == S_START)) else $error("last not converted");
  a_one_stack_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.push && cmd_o.pop)) else $error("push and pop together");

endmodule

[sim/infix_to_prefix_converter_test.sv]
`timescale 1ns / 1ps

module infix_to_prefix_converter_test;
  import itop_pkg::*;

  localparam int unsigned TEXT_DEPTH = 64;
  localparam int unsigned DIR_N = 24;
  localparam int unsigned RANDOM_ITEMS = 285;
  localparam int unsigned CALM_AFTER = 225;      // no idling past this many random items
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] st;
  } prefix_item_t;

  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    logic         typed;   // exp holds the one result of this expression
    prefix_item_t exp;
  } stim_row_t;

  localparam prefix_item_t NO_RESULT = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  always #5 clk_i = ~clk_i;

  infix_to_prefix_converter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tuser_o (m_tuser)
  );

  // Expression text as the block sees it, and the prefix results still owed
  logic [7:0]   expr_text [TEXT_DEPTH];
  int unsigned  expr_len;
  bit           expr_dropped;
  prefix_item_t prefix_due_q [$];
  prefix_item_t fresh_prefix [$];
  logic [7:0]   expr_chars [$];

  stim_row_t    dir_rows [DIR_N];
  int           fail_count = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           rx_hold_req = 1'b0;

  function automatic logic [1:0] op_binding(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS:         return RANK_ADD;
      CH_STAR, CH_SLASH, CH_PCT: return RANK_MUL;
      CH_CARET:                  return RANK_POW;
      default:                   return RANK_NONE;
    endcase
  endfunction

  function automatic bit is_term_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Reverse scan with an operator stack; fills fresh_prefix with the results
  function automatic void build_prefix();
    logic [7:0] ops [$];
    logic [7:0] rev [$];
    logic [7:0] c;
    logic [1:0] r;
    logic [1:0] st;
    fresh_prefix.delete();
    for (int i = int'(expr_len) - 1; i >= 0; i--) begin
      c = expr_text[i];
      if (is_term_char(c)) begin
        rev.push_back(c);
      end else if (c == CH_RPAREN) begin
        ops.push_back(c);
      end else if (c == CH_LPAREN) begin
        // pop down to the matching ')', or empty the stack if unmatched
        while (ops.size() > 0 && ops[ops.size() - 1] != CH_RPAREN) rev.push_back(ops.pop_back());
        if (ops.size() > 0) void'(ops.pop_back());
      end else if (op_binding(c) != RANK_NONE) begin
        r = op_binding(c);
        // equal rank pops only for '^' (right associative)
        while (ops.size() > 0 && (op_binding(ops[ops.size() - 1]) > r ||
               (op_binding(ops[ops.size() - 1]) == r && c == CH_CARET))) begin
          rev.push_back(ops.pop_back());
        end
        ops.push_back(c);
      end
    end
    while (ops.size() > 0) begin
      c = ops.pop_back();
      if (c != CH_RPAREN) rev.push_back(c);  // leftover ')' vanishes
    end
    st = expr_dropped ? ST_TOO_LONG : ((rev.size() == 0) ? ST_EMPTY : ST_OK);
    if (rev.size() == 0) begin
      fresh_prefix.push_back('{CH_NONE, 1'b1, st});
    end else begin
      for (int k = rev.size() - 1; k >= 0; k--) fresh_prefix.push_back('{rev[k], k == 0, st});
    end
  endfunction

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PCT;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic void build_wellformed(input int unsigned n_terms);
    int unsigned open_cnt;
    open_cnt = 0;
    expr_chars.delete();
    for (int unsigned t = 0; t < n_terms; t++) begin
      if (t > 0) expr_chars.push_back(rand_operator());
      while ($urandom_range(0, 3) == 0 && open_cnt < 4) begin
        expr_chars.push_back(CH_LPAREN);
        open_cnt++;
      end
      if ($urandom_range(0, 9) == 0) expr_chars.push_back(CH_SPACE);
      expr_chars.push_back(rand_operand());
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        expr_chars.push_back(CH_RPAREN);
        open_cnt--;
      end
    end
    while (open_cnt > 0) begin
      expr_chars.push_back(CH_RPAREN);
      open_cnt--;
    end
  endfunction

  // Unbalanced mix of operands, operators, parentheses and random bytes
  function automatic void build_soup(input int unsigned n_chars);
    expr_chars.delete();
    repeat (n_chars) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: expr_chars.push_back(rand_operand());
        4, 5, 6:    expr_chars.push_back(rand_operator());
        7:          expr_chars.push_back(CH_LPAREN);
        8:          expr_chars.push_back(CH_RPAREN);
        default:    expr_chars.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void build_noise(input int unsigned n_chars);
    expr_chars.delete();
    repeat (n_chars) expr_chars.push_back(8'($urandom_range(0, 255)));
  endfunction

  // One input transaction; the predictor updates when it is accepted
  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input prefix_item_t exp);
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    if (expr_len < TEXT_DEPTH) begin
      expr_text[expr_len] = ch;
      expr_len++;
    end else begin
      expr_dropped = 1'b1;
    end
    if (last) begin
      build_prefix();
      if (typed) prefix_due_q.push_back(exp);
      else foreach (fresh_prefix[i]) prefix_due_q.push_back(fresh_prefix[i]);
      expr_len = 0;
      expr_dropped = 1'b0;
    end
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, NO_RESULT);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (prefix_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    prefix_item_t got;
    prefix_item_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tlast, m_tuser};
      if (prefix_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ch=%h last=%b status=%0d",
                 $time, got.ch, got.last, got.st);
        fail_count++;
      end else begin
        want = prefix_due_q.pop_front();
        if (got.ch != want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, got.ch);
          fail_count++;
        end
        if (got.last != want.last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, got.last);
          fail_count++;
        end
        if (got.st != want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("infix_to_prefix_converter: mismatch");
    $finish;
  end

  initial begin
    int unsigned rnd_items;
    int unsigned expr_idx;
    // Directed rows: singles after reset and the extremes of the byte, then
    // precedence, right associativity, unmatched '(' and a leftover ')'
    dir_rows = '{
      '{"a",       1'b1, 1'b1, '{"a", 1'b1, ST_OK}},
      '{CH_LPAREN, 1'b1, 1'b1, '{CH_NONE, 1'b1, ST_EMPTY}},
      '{8'hFF,     1'b1, 1'b1, '{CH_NONE, 1'b1, ST_EMPTY}},
      '{CH_NONE,   1'b1, 1'b1, '{CH_NONE, 1'b1, ST_EMPTY}},
      '{"a",       1'b0, 1'b0, NO_RESULT},
      '{CH_PLUS,   1'b0, 1'b0, NO_RESULT},
      '{"b",       1'b0, 1'b0, NO_RESULT},
      '{CH_STAR,   1'b0, 1'b0, NO_RESULT},
      '{"c",       1'b1, 1'b0, NO_RESULT},
      '{"x",       1'b0, 1'b0, NO_RESULT},
      '{CH_CARET,  1'b0, 1'b0, NO_RESULT},
      '{"y",       1'b0, 1'b0, NO_RESULT},
      '{CH_CARET,  1'b0, 1'b0, NO_RESULT},
      '{"z",       1'b1, 1'b0, NO_RESULT},
      '{CH_LPAREN, 1'b0, 1'b0, NO_RESULT},
      '{"a",       1'b0, 1'b0, NO_RESULT},
      '{CH_MINUS,  1'b0, 1'b0, NO_RESULT},
      '{"b",       1'b0, 1'b0, NO_RESULT},
      '{CH_PCT,    1'b0, 1'b0, NO_RESULT},
      '{"c",       1'b0, 1'b0, NO_RESULT},
      '{CH_SLASH,  1'b0, 1'b0, NO_RESULT},
      '{"d",       1'b1, 1'b0, NO_RESULT},
      '{"a",       1'b0, 1'b0, NO_RESULT},
      '{CH_RPAREN, 1'b1, 1'b1, '{"a", 1'b1, ST_OK}}
    };
    expr_len = 0;
    expr_dropped = 1'b0;
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    m_tready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp);
    end
    // sender pauses until every result is back
    wait_drained();
    @(posedge clk_i);

    rnd_items = 0;
    expr_idx = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      if (expr_idx == 0) begin
        build_soup(TEXT_DEPTH);                        // exactly fills the buffer
      end else if (expr_idx == 1) begin
        build_soup($urandom_range(TEXT_DEPTH + 1, TEXT_DEPTH + 6));  // overflows
      end else begin
        if (expr_idx == 2) rx_hold_req = 1'b1;         // receiver backs up the block
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: build_wellformed($urandom_range(1, 6));
          7:                   build_soup($urandom_range(1, 8));
          default:             build_noise($urandom_range(1, 6));
        endcase
      end
      send_expr();
      rnd_items += expr_chars.size();
      expr_idx++;
      if (rnd_items >= CALM_AFTER) begin
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b0;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && prefix_due_q.size() == 0) begin
      $display("infix_to_prefix_converter: match");
    end else begin
      $display("infix_to_prefix_converter: mismatch");
    end
    $finish;
  end

endmodule
